>>> rtl/core/jddm_pkg.sv
// Shared types and constants for the joystick differential-drive mixer.
package jddm_pkg;

    // Default parameter values
    localparam int DUTY_BITS_DEF  = 10;
    localparam int JOY_CENTRE_DEF = 127;

    // Fixed field widths
    localparam int DUTY_W = 10;
    localparam int JOY_W  = 8;
    localparam int PAT_W  = 4;
    localparam int Q_W    = 17;   // unsigned Q1.16, 0..1.0 inclusive
    localparam int JOY_N  = 1 << JOY_W;

    // Queue depths
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // Q16 constants
    localparam longint Q_ONE = 65536;
    localparam longint K_PIV = 22938;   // 0.35
    localparam longint K_ARC = 42598;   // 0.65
    localparam longint K_FAR = 108134;  // 1.65

    // H-bridge patterns, IN1..IN4 msb first
    localparam logic [PAT_W-1:0] PAT_FWD   = 4'b0101;
    localparam logic [PAT_W-1:0] PAT_REV   = 4'b1010;
    localparam logic [PAT_W-1:0] PAT_LEFT  = 4'b0110;
    localparam logic [PAT_W-1:0] PAT_RIGHT = 4'b1001;
    localparam logic [PAT_W-1:0] PAT_STOP  = 4'b0000;

    // Configuration register index
    localparam logic REG_DRIVE_SCALE = 1'b0;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             left_half;
        logic [Q_W-1:0]   speed;    // speed scale s
        logic [Q_W-1:0]   factor;   // inner-wheel factor f
    } t_mix_job;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [PAT_W-1:0]  pattern;
    } t_mix_res;

endpackage

>>> rtl/core/jddm_fifo.sv
// Small synchronous queue carrying one packed record per entry.
module jddm_fifo import jddm_pkg::*; #(
    parameter type T     = t_mix_res,
    parameter int  DEPTH = RES_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_wr_data,
    input  logic                       i_pop,
    output T                           o_rd_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            wr_en;
    logic            rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/jddm_front.sv
// Front end: accepts joystick samples, classifies the band and looks up s and f.
module jddm_front import jddm_pkg::*; #(
    parameter int JOY_CENTRE = JOY_CENTRE_DEF
) (
    input  logic             i_push,
    input  logic [JOY_W-1:0] i_joy_x,
    input  logic [JOY_W-1:0] i_joy_y,
    input  logic             i_job_full,
    output logic             o_job_push,
    output t_mix_job         o_job
);

    localparam int          CMP_W   = 13;
    localparam logic [CMP_W-1:0] CENTRE  = CMP_W'(JOY_CENTRE);
    localparam logic [CMP_W-1:0] FULL_DEFL = CMP_W'(2 * JOY_CENTRE);

    logic [Q_W-1:0] f_tab      [JOY_N];
    logic           arc_tab    [JOY_N];
    logic [Q_W-1:0] s_arc_tab  [JOY_N];
    logic [Q_W-1:0] s_piv_tab  [JOY_N];

    // Per-sample constants, worked out at elaboration
    for (genvar g = 0; g < JOY_N; g++) begin : g_lut
        localparam longint XQ    = (longint'(g) * Q_ONE) / JOY_CENTRE;
        localparam longint YV    = (g > 2 * JOY_CENTRE) ? 2 * JOY_CENTRE : g;
        localparam longint YQ    = (YV * Q_ONE) / JOY_CENTRE;
        localparam bit     LEFT  = (g < JOY_CENTRE);
        localparam bit     RIGHT = (g > JOY_CENTRE) && (g < 2 * JOY_CENTRE);
        localparam bit     ARC   = LEFT ? (XQ > K_PIV) : (RIGHT ? (XQ < K_FAR) : 1'b0);
        localparam longint F_L   = ARC ? ((XQ - K_PIV) * Q_ONE) / K_ARC
                                       : Q_ONE - (XQ * Q_ONE) / K_PIV;
        localparam longint F_R   = ARC ? Q_ONE - ((XQ - Q_ONE) * Q_ONE) / K_ARC
                                       : ((XQ - K_FAR) * Q_ONE) / K_PIV;
        localparam longint F     = LEFT ? F_L : (RIGHT ? F_R : 0);
        localparam bit     FWD   = (g < JOY_CENTRE);
        localparam longint SA    = FWD ? Q_ONE - YQ : ((YQ >= Q_ONE) ? YQ - Q_ONE : 0);
        localparam longint SP    = FWD ? YQ : 2 * Q_ONE - YQ;

        assign f_tab[g]     = Q_W'(F);
        assign arc_tab[g]   = ARC;
        assign s_arc_tab[g] = Q_W'(SA);
        assign s_piv_tab[g] = Q_W'(SP);
    end

    logic [CMP_W-1:0] jx;
    logic [CMP_W-1:0] jy;
    logic             y_centre;
    logic             x_dead;
    logic             fwd;
    logic             left_half;
    logic             arc;

    assign jx        = CMP_W'(i_joy_x);
    assign jy        = CMP_W'(i_joy_y);
    assign y_centre  = (jy == CENTRE);
    assign x_dead    = (jx == '0) || (jx == CENTRE) || (jx >= FULL_DEFL);
    assign fwd       = (jy < CENTRE);
    assign left_half = (jx < CENTRE);
    assign arc       = arc_tab[i_joy_x];

    always_comb begin
        o_job.left_half = left_half;
        if (y_centre) begin
            // Vertical centre: both wheels at full scale
            o_job.speed  = Q_W'(Q_ONE);
            o_job.factor = Q_W'(Q_ONE);
            if (jx == '0) begin
                o_job.pattern = PAT_LEFT;
            end else if (jx == FULL_DEFL) begin
                o_job.pattern = PAT_RIGHT;
            end else begin
                o_job.pattern = PAT_STOP;
            end
        end else begin
            o_job.factor = f_tab[i_joy_x];
            o_job.speed  = arc ? s_arc_tab[i_joy_y] : s_piv_tab[i_joy_y];
            if (arc) begin
                o_job.pattern = fwd ? PAT_FWD : PAT_REV;
            end else if (fwd == left_half) begin
                o_job.pattern = PAT_LEFT;
            end else begin
                o_job.pattern = PAT_RIGHT;
            end
        end
    end

    // Dead points are taken and dropped here
    assign o_job_push = i_push && !i_job_full && (y_centre || !x_dead);

endmodule

>>> rtl/core/jddm_back.sv
// Back end: two multiplier stages turning s and f into the motor duties.
module jddm_back import jddm_pkg::*; #(
    parameter int OUT_DEPTH = RES_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [DUTY_W-1:0]              i_drive_scale,
    input  t_mix_job                       i_job,
    input  logic                           i_job_empty,
    output logic                           o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_res_count,
    output logic                           o_res_valid,
    output t_mix_res                       o_res
);

    localparam int OCW  = $clog2(OUT_DEPTH + 1);
    localparam int P1_W = DUTY_W + Q_W;
    localparam int P2_W = P1_W + Q_W;

    logic                   r_v1;
    logic                   r_v2;
    logic [P1_W-1:0]        r_prod1;
    logic [Q_W-1:0]         r_factor;
    logic                   r_left;
    logic [PAT_W-1:0]       r_pat1;
    t_mix_res               r_res;
    logic [OCW:0]           committed;
    logic [P2_W-1:0]        prod2;
    logic [DUTY_W-1:0]      outer;
    logic [DUTY_W-1:0]      inner;

    // Issue only when the result queue has room for everything in flight
    assign committed = (OCW+1)'(i_res_count) + (OCW+1)'(r_v1) + (OCW+1)'(r_v2);
    assign o_job_pop = !i_job_empty && (committed < (OCW+1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_job_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod1  <= P1_W'(i_drive_scale) * P1_W'(i_job.speed);
        r_factor <= i_job.factor;
        r_left   <= i_job.left_half;
        r_pat1   <= i_job.pattern;
    end

    assign prod2 = P2_W'(r_prod1) * P2_W'(r_factor);
    assign outer = r_prod1[16 +: DUTY_W];
    assign inner = prod2[32 +: DUTY_W];

    always_ff @(posedge i_clk) begin
        r_res.duty_a  <= r_left ? inner : outer;
        r_res.duty_b  <= r_left ? outer : inner;
        r_res.pattern <= r_pat1;
    end

    assign o_res_valid = r_v2;
    assign o_res       = r_res;

endmodule

>>> rtl/core/joystick_differential_drive_mixer_unit.sv
// Top level of the joystick differential-drive mixer.
// Takes one joystick sample per clock and turns it into two PWM duties and an
// H-bridge pattern. A sample is taken when push is high and full is low; samples
// at a horizontal dead point (x at zero, centre or full right while y is off
// centre) are taken and give no result. A result reaches the output side after
// its sample passes the job queue, the two registered multiplier stages (scale
// by speed, then by the inner-wheel factor) and the result queue write; after
// that one result leaves per cycle while pop is held.
// drive_scale sits at byte address 0 of the APB port and should be written only
// while the block is idle.
module joystick_differential_drive_mixer_unit import jddm_pkg::*; #(
    parameter int DUTY_BITS  = DUTY_BITS_DEF,
    parameter int JOY_CENTRE = JOY_CENTRE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [JOY_W-1:0]  i_joy_x,
    input  logic [JOY_W-1:0]  i_joy_y,
    output logic              empty,
    input  logic              pop,
    output logic [DUTY_W-1:0] o_duty_a,
    output logic [DUTY_W-1:0] o_duty_b,
    output logic [PAT_W-1:0]  o_bridge_pattern,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DS_W = (DUTY_BITS < DUTY_W) ? DUTY_BITS : DUTY_W;
    localparam int RCW  = $clog2(RES_DEPTH + 1);
    localparam int JCW  = $clog2(JOB_DEPTH + 1);

    logic [DS_W-1:0]  r_drive_scale;
    logic             cfg_wr;

    t_mix_job         job_wr;
    t_mix_job         job_rd;
    logic             job_push;
    logic             job_pop;
    logic             job_full;
    logic             job_empty;
    logic [JCW-1:0]   job_count;

    t_mix_res         res_wr;
    t_mix_res         res_rd;
    logic             res_valid;
    logic             res_full;
    logic [RCW-1:0]   res_count;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DRIVE_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_scale <= '1;
        end else if (cfg_wr) begin
            r_drive_scale <= pwdata[DS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DRIVE_SCALE) ? 32'(r_drive_scale) : '0;

    jddm_front #(
        .JOY_CENTRE (JOY_CENTRE)
    ) u_front (
        .i_push     (push),
        .i_joy_x    (i_joy_x),
        .i_joy_y    (i_joy_y),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (job_wr)
    );

    assign full = job_full;

    jddm_fifo #(
        .T     (t_mix_job),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (job_push),
        .i_wr_data (job_wr),
        .i_pop     (job_pop),
        .o_rd_data (job_rd),
        .o_full    (job_full),
        .o_empty   (job_empty),
        .o_count   (job_count)
    );

    jddm_back #(
        .OUT_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_drive_scale (DUTY_W'(r_drive_scale)),
        .i_job         (job_rd),
        .i_job_empty   (job_empty),
        .o_job_pop     (job_pop),
        .i_res_count   (res_count),
        .o_res_valid   (res_valid),
        .o_res         (res_wr)
    );

    jddm_fifo #(
        .T     (t_mix_res),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_valid),
        .i_wr_data (res_wr),
        .i_pop     (pop),
        .o_rd_data (res_rd),
        .o_full    (res_full),
        .o_empty   (empty),
        .o_count   (res_count)
    );

    assign o_duty_a         = res_rd.duty_a;
    assign o_duty_b         = res_rd.duty_b;
    assign o_bridge_pattern = res_rd.pattern;

    // Credit check in the back end must keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !res_full)
        else $error("result transfer into a full result queue");

    a_job_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> (job_count != '0))
        else $error("job issued from an empty job queue");

    a_res_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |=> (res_count <= RCW'(RES_DEPTH)))
        else $error("result queue count out of range");

endmodule
